// File: design/wpb_pkg.sv
// Shared types, constants and control signal groups of the wheel period batcher.
package wpb_pkg;

	localparam int FIFO_DEPTH_DEF = 64;
	localparam int BATCH_DEF      = 16;

	localparam int TS_W  = 64;
	localparam int THR_W = 16;

	localparam logic [THR_W-1:0] THR_RESET = 16'd10;

	localparam logic [1:0] ACT_PULSE   = 2'd0;
	localparam logic [1:0] ACT_TICK    = 2'd1;
	localparam logic [1:0] ACT_DRAINED = 2'd2;

	typedef struct packed {
		logic [1:0]      action;
		logic [TS_W-1:0] timestamp;
		logic            host_inactive;
	} in_t;

	typedef struct packed {
		logic            notify_host;
		logic            period_valid;
		logic [TS_W-1:0] period;
		logic            last;
	} out_t;

	typedef struct packed {
		logic accept;
		logic rd;
		logic load_move;
		logic load_one;
	} cmd_t;

	typedef struct packed {
		logic move;
		logic out_free;
		logic rem_zero;
	} status_t;

endpackage

// File: design/wpb_ram.sv
// Generic single-write, single-read RAM with registered read data.
module wpb_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: design/wpb_ctrl.sv
// Sequencer of the wheel period batcher: item acceptance and result emission.
module wpb_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  wpb_pkg::status_t status,
	output wpb_pkg::cmd_t    cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RD   = 2'd1;
	localparam logic [1:0] ST_WR   = 2'd2;
	localparam logic [1:0] ST_ONE  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = status.move ? ST_RD : ST_ONE;
				end
			end
			ST_RD: begin
				cmd.rd  = 1'b1;
				state_d = ST_WR;
			end
			ST_WR: begin
				// hold the read data until the output register frees up
				if (status.out_free) begin
					cmd.load_move = 1'b1;
					state_d       = status.rem_zero ? ST_IDLE : ST_RD;
				end
			end
			ST_ONE: begin
				if (status.out_free) begin
					cmd.load_one = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// File: design/wpb_dp.sv
// Datapath of the wheel period batcher: period FIFO, counters and output register.
module wpb_dp #(
	parameter int FIFO_DEPTH = wpb_pkg::FIFO_DEPTH_DEF,
	parameter int BATCH      = wpb_pkg::BATCH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  wpb_pkg::in_t              in_data,
	input  logic                      cfg_we,
	input  logic [wpb_pkg::THR_W-1:0] cfg_wdata,
	output logic                      out_valid,
	input  logic                      out_stall,
	output wpb_pkg::out_t             out_data,
	input  wpb_pkg::cmd_t             cmd,
	output wpb_pkg::status_t          status
);

	localparam int AW   = $clog2(FIFO_DEPTH);
	localparam int CW   = $clog2(FIFO_DEPTH + 1);
	localparam int BW   = $clog2(BATCH + 1);
	localparam int NW   = (CW > BW) ? CW : BW;
	localparam int TS_W = wpb_pkg::TS_W;
	localparam int TW   = wpb_pkg::THR_W;

	logic [AW-1:0]   head_q;
	logic [AW-1:0]   tail_q;
	logic [CW-1:0]   count_q;
	logic [TS_W-1:0] prev_q;
	logic            first_q;
	logic            slot_q;
	logic [TW-1:0]   idle_q;
	logic [TW-1:0]   thr_q;
	logic            notify_q;
	logic [NW-1:0]   rem_q;
	wpb_pkg::out_t   out_q;
	logic            out_valid_q;

	logic [TS_W-1:0] period_w;
	logic            is_pulse;
	logic            is_tick;
	logic            push_w;
	logic [CW-1:0]   count_after;
	logic [NW-1:0]   cnt_n;
	logic [NW-1:0]   take_n;
	logic            batch_cond;
	logic            move_w;
	logic            notify_w;
	logic [TW-1:0]   idle_inc;
	logic            idle_hit;
	logic [TS_W-1:0] rd_data;

	assign is_pulse = (in_data.action == wpb_pkg::ACT_PULSE);
	assign is_tick  = (in_data.action == wpb_pkg::ACT_TICK);
	assign period_w = in_data.timestamp - prev_q;
	assign push_w   = is_pulse && !first_q && (period_w != '0)
	                  && (count_q < CW'(FIFO_DEPTH));

	assign count_after = count_q + CW'(push_w);
	assign cnt_n       = NW'(count_after);
	assign take_n      = (cnt_n < NW'(BATCH)) ? cnt_n : NW'(BATCH);

	assign idle_inc = idle_q + 1'b1;
	assign idle_hit = (idle_inc >= thr_q);

	always_comb begin
		batch_cond = 1'b0;
		notify_w   = 1'b0;
		case (in_data.action)
			wpb_pkg::ACT_PULSE: begin
				batch_cond = (cnt_n >= NW'(BATCH));
				notify_w   = batch_cond || in_data.host_inactive;
			end
			wpb_pkg::ACT_TICK: begin
				batch_cond = (count_q != '0);
				notify_w   = batch_cond || idle_hit;
			end
			default: begin
				batch_cond = 1'b0;
				notify_w   = 1'b0;
			end
		endcase
	end

	assign move_w = batch_cond && !slot_q;

	assign status.move     = move_w;
	assign status.out_free = !out_valid_q || !out_stall;
	assign status.rem_zero = (rem_q == '0);

	wpb_ram #(
		.WIDTH(TS_W),
		.DEPTH(FIFO_DEPTH)
	) u_fifo_ram (
		.clk   (clk),
		.we    (cmd.accept && push_w),
		.waddr (tail_q),
		.wdata (period_w),
		.re    (cmd.rd),
		.raddr (head_q),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			tail_q      <= '0;
			count_q     <= '0;
			prev_q      <= '0;
			first_q     <= 1'b1;
			slot_q      <= 1'b0;
			idle_q      <= '0;
			thr_q       <= wpb_pkg::THR_RESET;
			notify_q    <= 1'b0;
			rem_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				thr_q <= cfg_wdata;
			end
			if (cmd.accept) begin
				notify_q <= notify_w;
				rem_q    <= move_w ? take_n : '0;
				count_q  <= count_after - (move_w ? CW'(take_n) : '0);
				if (move_w) begin
					slot_q <= 1'b1;
				end else if (in_data.action == wpb_pkg::ACT_DRAINED) begin
					slot_q <= 1'b0;
				end
				if (push_w) begin
					tail_q <= (tail_q == AW'(FIFO_DEPTH - 1)) ? '0 : tail_q + 1'b1;
				end
				if (is_pulse) begin
					prev_q  <= in_data.timestamp;
					first_q <= 1'b0;
					idle_q  <= '0;
				end else if (is_tick) begin
					// reset the idle run on data or on reaching the threshold
					if (count_q != '0 || idle_hit) begin
						idle_q <= '0;
					end else begin
						idle_q <= idle_inc;
					end
				end
			end
			if (cmd.rd) begin
				head_q <= (head_q == AW'(FIFO_DEPTH - 1)) ? '0 : head_q + 1'b1;
				rem_q  <= rem_q - 1'b1;
			end
			if (cmd.load_move || cmd.load_one) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_move) begin
			out_q.notify_host  <= notify_q;
			out_q.period_valid <= 1'b1;
			out_q.period       <= rd_data;
			out_q.last         <= (rem_q == '0);
		end else if (cmd.load_one) begin
			out_q.notify_host  <= notify_q;
			out_q.period_valid <= 1'b0;
			out_q.period       <= '0;
			out_q.last         <= 1'b1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// File: design/wheel_period_batcher_unit.sv
// Top level of the wheel period batcher: sequencer and datapath.
//
// Input channel (in_valid, in_stall, in_data) takes one event item: a wheel
// pulse with its 64-bit timestamp, a timer tick, or a notice that the host
// has drained its batch. Output channel (out_valid, out_stall, out_data)
// gives the result items; an item yields either one plain result or a run
// of 1 to BATCH period results, oldest first, with last on the final one.
// cfg_we/cfg_wdata set the idle tick threshold; write it only while idle.
// Throughput: one item at a time. An item giving one result goes from
// acceptance through the ST_ONE state back to idle. The pace of a batch of n
// periods is set by the FIFO RAM: each period is read (registered read) in
// ST_RD and then loaded into the output register in ST_WR.
// A plain result is loaded into the output register in ST_ONE; the first
// result of a batch run is loaded in ST_WR after its read in ST_RD.
// A stalled output holds its result and the next result waits; no item is
// accepted until the last result of the current one is loaded.
// Reset clears the FIFO pointers and counters, marks the next pulse as the
// first one, empties the host slot and sets the threshold to 10 ticks.
module wheel_period_batcher_unit #(
	parameter int FIFO_DEPTH = wpb_pkg::FIFO_DEPTH_DEF,
	parameter int BATCH      = wpb_pkg::BATCH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  wpb_pkg::in_t              in_data,
	output logic                      out_valid,
	input  logic                      out_stall,
	output wpb_pkg::out_t             out_data,
	input  logic                      cfg_we,
	input  logic [wpb_pkg::THR_W-1:0] cfg_wdata
);

	wpb_pkg::cmd_t    cmd;
	wpb_pkg::status_t status;

	wpb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	wpb_dp #(
		.FIFO_DEPTH(FIFO_DEPTH),
		.BATCH     (BATCH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cmd       (cmd),
		.status    (status)
	);

endmodule
